/* design/ffa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the first-fit block allocator.
// No dependencies.
package ffa_pkg;

  localparam int DATA_W         = 21;
  localparam int START_W        = 20;
  localparam int MAX_BLOCKS_DEF = 256;
  localparam int META_BYTES     = 32;
  localparam int HEAP_BYTES     = 1048576;

  localparam logic [DATA_W-1:0] LIMIT_RESET = DATA_W'(1048576);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_REALLOC = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [DATA_W-1:0] req_size;
    logic [DATA_W-1:0] pointer;
  } req_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_pointer;
    logic [1:0]        status;
    logic [DATA_W-1:0] copy_len;
  } rsp_t;

  // One row of the block table.
  typedef struct packed {
    logic [START_W-1:0] start;
    logic [DATA_W-1:0]  size;
    logic               is_free;
  } entry_t;

endpackage

/* design/ffa_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/first_fit_block_allocator.sv */
`timescale 1ns / 1ps
// First-fit block allocator top level: request FSM around the block table.
// Depends on ffa_pkg and ffa_ram.
//
// One request (allocate, free, reallocate) is handled at a time. The block
// table lives in one RAM, one entry per cycle is read during a search:
// an allocate scans for the first free block that fits, a free looks up its
// pointer, and a moving reallocate does a pointer lookup, then a first-fit
// search, then frees the old block. Requests that need no search (size zero,
// null free, opcode 3) go straight to the result. The result sits in an
// output register, so the next request is taken while a finished result
// waits for out_ready. Blocks are never split; a new block is appended at
// the heap top when no free block fits, within min(heap_limit, HEAP_BYTES)
// and MAX_BLOCKS. No clearing pass is needed: only entries below
// block_count are ever read.
module first_fit_block_allocator #(
  parameter int MAX_BLOCKS = ffa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [ffa_pkg::DATA_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ffa_pkg::req_t             in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ffa_pkg::rsp_t             out_data
);
  import ffa_pkg::*;

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int NEED_W = DATA_W + 2;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FIND     = 3'd1;
  localparam logic [2:0] S_ALLOC    = 3'd2;
  localparam logic [2:0] S_FREE_OLD = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  logic [2:0]        state;
  logic [DATA_W-1:0] heap_limit;
  logic [CNT_W-1:0]  block_count;
  logic [DATA_W-1:0] heap_top;

  // captured request
  logic [1:0]        op_r;
  logic [DATA_W-1:0] size_r;
  logic [DATA_W-1:0] ptr_r;

  // search pipeline: address issued, data checked in the cycle after
  logic [CNT_W-1:0]  scan_idx;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;

  // old block of a moving reallocate
  logic               move;
  logic [IDX_W-1:0]   old_idx;
  logic [START_W-1:0] old_start;
  logic [DATA_W-1:0]  old_size;

  // pending result
  logic [DATA_W-1:0] res_ptr;
  logic [1:0]        res_st;
  logic [DATA_W-1:0] res_copy;

  // table RAM
  logic                     ram_we;
  logic [IDX_W-1:0]         ram_waddr;
  entry_t                   ram_wdata;
  logic                     ram_re;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t                   rd;

  logic              alloc_hit;
  logic              find_hit;
  logic              scan_done;
  logic              issue;
  logic [DATA_W-1:0] lim;
  logic [NEED_W-1:0] need;
  logic              grow_ok;
  logic [DATA_W-1:0] rd_user;
  logic [DATA_W-1:0] top_user;
  logic              out_load;

  ffa_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(scan_idx[IDX_W-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    rd        = entry_t'(ram_rdata);
    rd_user   = {1'b0, rd.start} + DATA_W'(META_BYTES);
    top_user  = heap_top + DATA_W'(META_BYTES);
    alloc_hit = rd_vld && rd.is_free && (rd.size >= size_r);
    find_hit  = rd_vld && (rd_user == ptr_r);
    scan_done = (scan_idx >= block_count);
    issue     = ((state == S_ALLOC) && !alloc_hit && !scan_done) ||
                ((state == S_FIND) && !find_hit && !scan_done);
    ram_re    = issue;

    // limit in force is the smaller of the register and the heap size
    lim  = (heap_limit < DATA_W'(HEAP_BYTES)) ? heap_limit : DATA_W'(HEAP_BYTES);
    need = {2'b00, heap_top} + NEED_W'(META_BYTES) + {2'b00, size_r};
    grow_ok = (block_count < CNT_W'(MAX_BLOCKS)) && (need <= {2'b00, lim});

    ram_we    = 1'b0;
    ram_waddr = rd_idx;
    ram_wdata = '{start: rd.start, size: rd.size, is_free: 1'b0};
    case (state)
      S_ALLOC: begin
        if (alloc_hit) begin
          ram_we = 1'b1;                        // reuse: mark in use
        end else if (scan_done && grow_ok) begin
          ram_we    = 1'b1;                     // append at heap top
          ram_waddr = block_count[IDX_W-1:0];
          ram_wdata = '{start: heap_top[START_W-1:0], size: size_r, is_free: 1'b0};
        end
      end
      S_FIND: begin
        if (find_hit && !rd.is_free && (op_r == OP_FREE)) begin
          ram_we    = 1'b1;
          ram_wdata = '{start: rd.start, size: rd.size, is_free: 1'b1};
        end
      end
      S_FREE_OLD: begin
        ram_we    = 1'b1;
        ram_waddr = old_idx;
        ram_wdata = '{start: old_start, size: old_size, is_free: 1'b1};
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      heap_limit  <= LIMIT_RESET;
      block_count <= '0;
      heap_top    <= '0;
      rd_vld      <= 1'b0;
      scan_idx    <= '0;
      move        <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        heap_limit <= cfg_wr_data;
      end

      rd_vld   <= issue;
      rd_idx   <= scan_idx[IDX_W-1:0];

      if (out_load) begin
        out_valid <= 1'b1;
        out_data  <= '{result_pointer: res_ptr, status: res_st, copy_len: res_copy};
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_data.opcode;
            size_r   <= in_data.req_size;
            ptr_r    <= in_data.pointer;
            move     <= 1'b0;
            scan_idx <= '0;
            res_ptr  <= '0;
            res_copy <= '0;
            case (in_data.opcode)
              OP_ALLOC: begin
                if (in_data.req_size == '0) begin
                  res_st <= ST_NULL;
                  state  <= S_DONE;
                end else begin
                  res_st <= ST_OK;
                  state  <= S_ALLOC;
                end
              end
              OP_FREE: begin
                res_st <= ST_OK;
                state  <= (in_data.pointer == '0) ? S_DONE : S_FIND;
              end
              OP_REALLOC: begin
                if (in_data.pointer != '0) begin
                  res_st <= ST_OK;
                  state  <= S_FIND;
                end else if (in_data.req_size == '0) begin
                  res_st <= ST_NULL;
                  state  <= S_DONE;
                end else begin
                  res_st <= ST_OK;
                  state  <= S_ALLOC;
                end
              end
              default: begin
                res_st <= ST_OK;
                state  <= S_DONE;               // opcode 3: no operation
              end
            endcase
          end
        end

        S_FIND: begin
          if (find_hit) begin
            if (rd.is_free) begin
              res_st <= ST_BAD;                 // double free / free block
              state  <= S_DONE;
            end else if (op_r == OP_FREE) begin
              state <= S_DONE;                  // freed by the table write
            end else if (rd.size >= size_r) begin
              res_ptr <= ptr_r;                 // realloc fits in place
              state   <= S_DONE;
            end else begin
              move      <= 1'b1;
              old_idx   <= rd_idx;
              old_start <= rd.start;
              old_size  <= rd.size;
              scan_idx  <= '0;
              state     <= S_ALLOC;
            end
          end else if (scan_done) begin
            res_st <= ST_BAD;                   // unknown pointer
            state  <= S_DONE;
          end else begin
            scan_idx <= scan_idx + CNT_W'(1);   // next entry issued this cycle
          end
        end

        S_ALLOC: begin
          if (alloc_hit) begin
            res_ptr  <= rd_user;
            res_copy <= move ? old_size : '0;
            state    <= move ? S_FREE_OLD : S_DONE;
          end else if (scan_done) begin
            if (grow_ok) begin
              block_count <= block_count + 1'b1;
              heap_top    <= need[DATA_W-1:0];
              res_ptr     <= top_user;
              res_copy    <= move ? old_size : '0;
              state       <= move ? S_FREE_OLD : S_DONE;
            end else begin
              res_st <= ST_NULL;                // old block stays in use
              state  <= S_DONE;
            end
          end else begin
            scan_idx <= scan_idx + CNT_W'(1);
          end
        end

        S_FREE_OLD: begin
          state <= S_DONE;
        end

        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    block_count <= CNT_W'(MAX_BLOCKS))
    else $error("block_count beyond table depth");

  a_top_bound: assert property (@(posedge clk) disable iff (rst)
    heap_top <= DATA_W'(HEAP_BYTES))
    else $error("heap_top beyond heap size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (block_count == $past(block_count)) ||
                    (block_count == $past(block_count) + 1'b1))
    else $error("block_count moved by more than one");

  a_top_with_count: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (heap_top != $past(heap_top))) |->
      (block_count == $past(block_count) + 1'b1))
    else $error("heap_top grew without a new block");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status == ST_BAD)) |->
      ((out_data.result_pointer == '0) && (out_data.copy_len == '0)))
    else $error("bad pointer result carries data");
`endif

endmodule

/* bench/tb_first_fit_block_allocator.sv */
`timescale 1ns / 1ps
// Self-checking bench for first_fit_block_allocator: a directed request table,
// then random allocate/free/reallocate traffic scored against a block-table mirror.
// Depends on ffa_pkg and the first_fit_block_allocator RTL.
module tb_first_fit_block_allocator;
  import ffa_pkg::*;

  localparam int          TABLE_DEPTH = MAX_BLOCKS_DEF;
  localparam logic [1:0]  OP_NOP      = 2'd3;   // unused opcode, must act as a no-op

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [DATA_W-1:0] cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  req_t              in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  rsp_t              out_data;

  first_fit_block_allocator DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  always #5 clk = ~clk;

  // Mirror of the block table. Only entries below blk_count are ever read.
  logic [DATA_W-1:0] blk_start [TABLE_DEPTH];
  logic [DATA_W-1:0] blk_size  [TABLE_DEPTH];
  bit                blk_free  [TABLE_DEPTH];
  int unsigned       blk_count = 0;
  int unsigned       heap_top_now = 0;
  logic [DATA_W-1:0] limit_reg = LIMIT_RESET;

  rsp_t replies [$];      // responses still owed by the block, oldest first
  int   fail_count = 0;
  int   src_idle_pct = 0; // chance of a sender gap before a request
  int   snk_idle_pct = 0; // chance of a receiver stall burst
  int   stall_left = 0;

  typedef struct {
    req_t req;
    bit   literal;        // reply typed in below rather than taken from the mirror
    rsp_t reply;
  } dir_row_t;

  dir_row_t dir_rows [$];

  // First fit over the table, else append at heap top. Returns user pointer or 0.
  function automatic logic [DATA_W-1:0] grant_block(logic [DATA_W-1:0] size);
    int unsigned lim;
    int unsigned need;
    if (size == 0) return '0;
    for (int i = 0; i < blk_count; i++) begin
      if (blk_free[i] && blk_size[i] >= size) begin
        blk_free[i] = 1'b0;
        return DATA_W'(blk_start[i] + META_BYTES);
      end
    end
    if (blk_count >= TABLE_DEPTH) return '0;
    lim  = (limit_reg > HEAP_BYTES) ? HEAP_BYTES : limit_reg;
    need = heap_top_now + META_BYTES + size;
    if (need > lim) return '0;
    blk_start[blk_count] = DATA_W'(heap_top_now);
    blk_size[blk_count]  = size;
    blk_free[blk_count]  = 1'b0;
    blk_count++;
    heap_top_now = need;
    return DATA_W'(blk_start[blk_count-1] + META_BYTES);
  endfunction

  // Index of the in-use block owning this user pointer, or -1.
  function automatic int live_index(logic [DATA_W-1:0] ptr);
    for (int i = 0; i < blk_count; i++) begin
      if (blk_start[i] + META_BYTES == ptr) return blk_free[i] ? -1 : i;
    end
    return -1;
  endfunction

  // Applies one request to the mirror and returns the response it must produce.
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int   idx;
    o = '0;
    o.status = ST_OK;
    case (r.opcode)
      OP_ALLOC: begin
        o.result_pointer = grant_block(r.req_size);
        o.status = (o.result_pointer != 0) ? ST_OK : ST_NULL;
      end
      OP_FREE: begin
        if (r.pointer != 0) begin
          idx = live_index(r.pointer);
          if (idx < 0) o.status = ST_BAD;
          else blk_free[idx] = 1'b1;
        end
      end
      OP_REALLOC: begin
        if (r.pointer == 0) begin
          o.result_pointer = grant_block(r.req_size);
          o.status = (o.result_pointer != 0) ? ST_OK : ST_NULL;
        end else begin
          idx = live_index(r.pointer);
          if (idx < 0) begin
            o.status = ST_BAD;
          end else if (blk_size[idx] >= r.req_size) begin
            o.result_pointer = r.pointer;
          end else begin
            // moving realloc: the old block is released only if the new grant worked
            o.result_pointer = grant_block(r.req_size);
            if (o.result_pointer == 0) begin
              o.status = ST_NULL;
            end else begin
              o.copy_len = blk_size[idx];
              blk_free[idx] = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  task automatic add_row(logic [1:0] op, int unsigned size, int unsigned ptr,
                         bit literal, int unsigned rptr, logic [1:0] st);
    dir_row_t row;
    row.req.opcode   = op;
    row.req.req_size = DATA_W'(size);
    row.req.pointer  = DATA_W'(ptr);
    row.literal      = literal;
    row.reply.result_pointer = DATA_W'(rptr);
    row.reply.status         = st;
    row.reply.copy_len       = '0;
    dir_rows.push_back(row);
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send(req_t r, bit literal, rsp_t lit_reply);
    rsp_t want;
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_data  = r;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = apply_request(r);
    replies.push_back(literal ? lit_reply : want);
    @(negedge clk);
  endtask

  // Register writes only with the block drained.
  task automatic set_heap_limit(logic [DATA_W-1:0] value);
    in_valid = 1'b0;
    while (replies.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    limit_reg = value;
  endtask

  // Random requests; pointers mostly name table entries (live or freed),
  // the rest null or noise.
  task automatic run_phase(int n, int alloc_w, int free_w, int small_cap, int big_pct);
    req_t r;
    int   pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 2)                       r.opcode = OP_NOP;
      else if (pick < 2 + alloc_w)        r.opcode = OP_ALLOC;
      else if (pick < 2 + alloc_w + free_w) r.opcode = OP_FREE;
      else                                r.opcode = OP_REALLOC;
      pick = $urandom_range(0, 99);
      if (pick < 3)                 r.req_size = '0;
      else if (pick < 3 + big_pct)  r.req_size = DATA_W'($urandom_range(1, HEAP_BYTES));
      else                          r.req_size = DATA_W'($urandom_range(1, small_cap));
      pick = $urandom_range(0, 99);
      if (pick < 10 || blk_count == 0) r.pointer = '0;
      else if (pick < 25)              r.pointer = DATA_W'($urandom_range(1, HEAP_BYTES));
      else r.pointer = DATA_W'(blk_start[$urandom_range(0, blk_count - 1)] + META_BYTES);
      send(r, 1'b0, '0);
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Receiver: ready drops in bursts of random length.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < snk_idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Score every response transfer against the oldest owed response.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && out_valid && out_ready) begin
      if (replies.size() == 0) begin
        $display("%0t: response with none owed, expected nothing, actual %h",
                 $time, out_data);
        fail_count++;
      end else begin
        want = replies.pop_front();
        check_field("result_pointer", 32'(want.result_pointer),
                    32'(out_data.result_pointer));
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("copy_len", 32'(want.copy_len), 32'(out_data.copy_len));
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("FAIL first_fit_block_allocator");
    $finish;
  end

  initial begin : stimulus
    int lim_pick;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_heap_limit(LIMIT_RESET);

    // Fresh heap: the first grant lands at META_BYTES, the next right after it.
    //      op          size      ptr       lit  result ptr  status
    add_row(OP_ALLOC,   0,        0,        1,   0,          ST_NULL); // zero size
    add_row(OP_FREE,    0,        0,        1,   0,          ST_OK);   // free of null
    add_row(OP_NOP,     1048576,  1048576,  1,   0,          ST_OK);   // opcode 3
    add_row(OP_FREE,    0,        1048576,  1,   0,          ST_BAD);  // unknown pointer
    add_row(OP_REALLOC, 5,        33,       1,   0,          ST_BAD);  // not a block
    add_row(OP_ALLOC,   100,      0,        1,   32,         ST_OK);
    add_row(OP_ALLOC,   1,        0,        1,   164,        ST_OK);
    add_row(OP_FREE,    0,        32,       1,   0,          ST_OK);
    add_row(OP_FREE,    0,        32,       1,   0,          ST_BAD);  // double free
    add_row(OP_REALLOC, 10,       32,       1,   0,          ST_BAD);  // realloc of freed
    add_row(OP_ALLOC,   50,       0,        0,   0,          ST_OK);   // reuse, no split
    add_row(OP_REALLOC, 100,      32,       0,   0,          ST_OK);   // fits in place
    add_row(OP_REALLOC, 0,        32,       0,   0,          ST_OK);   // size zero fits
    add_row(OP_REALLOC, 200,      164,      0,   0,          ST_OK);   // must move
    add_row(OP_REALLOC, 1,        0,        0,   0,          ST_OK);   // null acts as alloc
    add_row(OP_ALLOC,   1048576,  0,        1,   0,          ST_NULL); // over the limit
    add_row(OP_REALLOC, 1048576,  197,      0,   0,          ST_OK);   // move fails
    add_row(OP_FREE,    0,        197,      0,   0,          ST_OK);   // old block kept
    add_row(OP_ALLOC,   1048575,  0,        1,   0,          ST_NULL);
    add_row(OP_REALLOC, 0,        0,        1,   0,          ST_NULL); // null, size zero
    add_row(OP_FREE,    0,        1048575,  1,   0,          ST_BAD);
    src_idle_pct = 30;
    snk_idle_pct = 30;
    foreach (dir_rows[i]) send(dir_rows[i].req, dir_rows[i].literal, dir_rows[i].reply);

    // Limit exactly 1000 bytes of payload above the top: one byte more fails.
    set_heap_limit(DATA_W'(heap_top_now + META_BYTES + 1000));
    send('{opcode: OP_ALLOC, req_size: 1001, pointer: 0}, 1'b0, '0);
    send('{opcode: OP_ALLOC, req_size: 1000, pointer: 0}, 1'b0, '0);

    // Tight heap: growth runs out on space.
    set_heap_limit(DATA_W'($urandom_range(4096, 65536)));
    run_phase(150, 55, 20, 2048, 5);

    // Limit below the heap top: only reuse can succeed.
    set_heap_limit('0);
    run_phase(60, 40, 30, 512, 0);

    // Full heap, small blocks, allocation heavy: the table fills up.
    set_heap_limit(LIMIT_RESET);
    src_idle_pct = 20;
    snk_idle_pct = 40;
    run_phase(400, 70, 10, 256, 0);

    lim_pick = int'(heap_top_now) + int'($urandom_range(0, 16384)) - 4096;
    if (lim_pick < 0) lim_pick = 0;
    if (lim_pick > HEAP_BYTES) lim_pick = HEAP_BYTES;
    set_heap_limit(DATA_W'(lim_pick));
    src_idle_pct = 40;
    snk_idle_pct = 10;
    run_phase(60, 30, 40, 4096, 3);

    // Closing stretch at full rate on both sides.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    run_phase(80, 40, 30, 1024, 2);

    in_valid = 1'b0;
    while (replies.size() != 0) @(posedge clk);
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS first_fit_block_allocator");
    end else begin
      $display("FAIL first_fit_block_allocator");
    end
    $finish;
  end

endmodule

/* sim.f */
design/ffa_pkg.sv
design/ffa_ram.sv
design/first_fit_block_allocator.sv
bench/tb_first_fit_block_allocator.sv
